>>> hw/rtl/ast_pkg.sv
// Package for the application slot table: command and status codes, and the
// token that travels along the row of slot cells.
// No dependencies; used by ast_cell and app_slot_table.
`timescale 1ns / 1ps
`default_nettype none

package ast_pkg;

    // Default number of slots in the table.
    localparam int SLOTS_DEF = 16;

    // Field widths of one command.
    localparam int ID_W   = 31;
    localparam int ADDR_W = 32;

    // Width of the slot field of a result.
    localparam int SLOT_OUT_W = 4;

    // Command codes.
    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_REMOVE   = 1'b1;

    // Status codes of a result.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // A command on its way along the row, with a mark set once a cell has
    // taken it.
    typedef struct packed {
        logic              valid;
        logic              cmd;
        logic [ID_W-1:0]   app_id;
        logic              on_hardware;
        logic [ADDR_W-1:0] state_addr;
        logic [ADDR_W-1:0] log_addr;
        logic              new_alive;
        logic              hit;
    } t_token;

endpackage

`default_nettype wire

>>> hw/rtl/ast_cell.sv
// One slot of the application slot table: holds the slot's fields and acts on
// the command token passing through, then hands the token to the next cell.
// Depends on ast_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ast_cell
    import ast_pkg::*;
#(
    parameter int SLOT_W = 4,
    parameter int INDEX  = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire t_token            i_tok,
    input  wire logic [SLOT_W-1:0] i_found,
    output t_token                 o_tok,
    output logic [SLOT_W-1:0]      o_found
);

    // Slot contents.
    logic [ID_W-1:0]   r_id;
    logic              r_on_hw;
    logic [ADDR_W-1:0] r_state_addr;
    logic [ADDR_W-1:0] r_log_addr;
    logic              r_alive;

    // Token register towards the next cell.
    t_token            r_tok;
    t_token            n_tok;
    logic [SLOT_W-1:0] r_found;
    logic [SLOT_W-1:0] n_found;

    logic w_match;
    logic w_take;

    // A register command wants a free slot; a remove wants an equal id.
    always_comb begin
        if (i_tok.cmd == CMD_REGISTER) begin
            w_match = !r_alive;
        end else begin
            w_match = (r_id == i_tok.app_id);
        end
    end

    // Only the first matching cell along the row takes the command.
    assign w_take = i_en && i_tok.valid && !i_tok.hit && w_match;

    always_comb begin
        n_tok   = i_tok;
        n_found = i_found;
        if (w_take) begin
            n_tok.hit = 1'b1;
            n_found   = SLOT_W'(INDEX);
        end
    end

    // Slot storage update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id         <= '0;
            r_on_hw      <= 1'b0;
            r_state_addr <= '0;
            r_log_addr   <= '0;
            r_alive      <= 1'b0;
        end else if (w_take) begin
            if (i_tok.cmd == CMD_REGISTER) begin
                r_id         <= i_tok.app_id;
                r_on_hw      <= i_tok.on_hardware;
                r_state_addr <= i_tok.state_addr;
                r_log_addr   <= i_tok.log_addr;
                r_alive      <= i_tok.new_alive;
            end else begin
                r_alive <= 1'b0;
            end
        end
    end

    // Token hand-over; the whole row holds while the result cannot leave.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_found <= '0;
        end else if (i_en) begin
            r_tok   <= n_tok;
            r_found <= n_found;
        end
    end

    assign o_tok   = r_tok;
    assign o_found = r_found;

endmodule

`default_nettype wire

>>> hw/rtl/app_slot_table.sv
// Application slot table: a row of SLOTS slot cells through which each command
// travels one cell per clock while no result waits at the end of the row. The
// lowest free slot takes a register command, and the lowest slot holding the id
// takes a remove command; the result is presented from the output register, and
// a new command is taken only once the last one has left the row for that
// register. A waiting result sits in the output register while the next command
// walks the row. All slots are clear after reset. Depends on ast_pkg and
// ast_cell.
`timescale 1ns / 1ps
`default_nettype none

module app_slot_table
    import ast_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_cmd,
    input  wire logic [ID_W-1:0]       i_app_id,
    input  wire logic                  i_on_hardware,
    input  wire logic [ADDR_W-1:0]     i_state_addr,
    input  wire logic [ADDR_W-1:0]     i_log_addr,
    input  wire logic                  i_new_alive,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [1:0]                 o_status,
    output logic [SLOT_OUT_W-1:0]      o_slot
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_token            w_tok   [0:SLOTS];
    logic [SLOT_W-1:0] w_found [0:SLOTS];
    logic [SLOTS-1:0]  w_vld;

    logic r_busy;
    logic r_out_valid;
    logic [1:0] r_status;
    logic [SLOT_OUT_W-1:0] r_slot;

    logic w_accept;
    logic w_move;
    logic w_en;
    t_token w_last;
    t_token w_head;

    // Command enters the first cell on the transfer itself.
    assign o_ready  = !r_busy;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        w_head.valid       = w_accept;
        w_head.cmd         = i_cmd;
        w_head.app_id      = i_app_id;
        w_head.on_hardware = i_on_hardware;
        w_head.state_addr  = i_state_addr;
        w_head.log_addr    = i_log_addr;
        w_head.new_alive   = i_new_alive;
        w_head.hit         = 1'b0;
    end
    assign w_tok[0]   = w_head;
    assign w_found[0] = '0;

    // The row of slot cells.
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ast_cell #(
            .SLOT_W (SLOT_W),
            .INDEX  (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tok   (w_tok[g]),
            .i_found (w_found[g]),
            .o_tok   (w_tok[g+1]),
            .o_found (w_found[g+1])
        );
        assign w_vld[g] = w_tok[g+1].valid;
    end

    // The token leaves the last cell once the output register is free.
    assign w_last = w_tok[SLOTS];
    assign w_move = w_last.valid && (!r_out_valid || i_ready);
    assign w_en   = !w_last.valid || w_move;

    // One command in the row at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_move) begin
            r_busy <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            if (w_last.hit) begin
                r_status <= ST_OK;
                r_slot   <= SLOT_OUT_W'(w_found[SLOTS]);
            end else begin
                r_status <= (w_last.cmd == CMD_REMOVE) ? ST_NOT_FOUND : ST_FULL;
                r_slot   <= '0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_slot   = r_slot;

`ifndef SYNTH
    // Never more than one command walking the row.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld) <= 1)
        else $error("more than one command in the slot row");

    // The busy flag tracks exactly whether the row holds a command.
    a_busy_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (w_vld != '0))
        else $error("busy flag disagrees with the slot row");

    // A new command is only taken into an empty row.
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (w_vld == '0))
        else $error("command taken while the row was busy");

    // A failed command reports slot zero.
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_slot == '0))
        else $error("failed command reports a non-zero slot");
`endif

endmodule

`default_nettype wire

>>> tb/tb_app_slot_table.sv
// Self-checking testbench for app_slot_table: directed tests followed by random
// traffic, with every result checked against an in-bench model of the table.
// Depends on ast_pkg and the app_slot_table RTL.
`timescale 1ns / 1ps

module tb_app_slot_table;
    import ast_pkg::*;

    localparam int N_SLOTS     = SLOTS_DEF;
    localparam int ID_POOL     = 12;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_OUT_W-1:0] slot;
    } t_slot_result;

    // Ports of the block; every input starts at a known value.
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_ready;
    logic                  i_cmd         = CMD_REGISTER;
    logic [ID_W-1:0]       i_app_id      = '0;
    logic                  i_on_hardware = 1'b0;
    logic [ADDR_W-1:0]     i_state_addr  = '0;
    logic [ADDR_W-1:0]     i_log_addr    = '0;
    logic                  i_new_alive   = 1'b0;
    logic                  o_valid;
    logic                  i_ready       = 1'b0;
    logic [1:0]            o_status;
    logic [SLOT_OUT_W-1:0] o_slot;

    // Model of the slot table, kept in step with accepted commands.
    logic [ID_W-1:0]   tbl_id    [N_SLOTS];
    logic              tbl_hw    [N_SLOTS];
    logic [ADDR_W-1:0] tbl_saddr [N_SLOTS];
    logic [ADDR_W-1:0] tbl_laddr [N_SLOTS];
    logic              tbl_alive [N_SLOTS];

    t_slot_result    pending_results[$];
    logic [ID_W-1:0] id_pool[ID_POOL];
    int              n_errors    = 0;
    int              n_checked   = 0;
    int              cycle_count = 0;
    int              tx_idle_pct = 0;
    int              rx_idle_pct = 0;

    app_slot_table #(
        .SLOTS(N_SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_app_id     (i_app_id),
        .i_on_hardware(i_on_hardware),
        .i_state_addr (i_state_addr),
        .i_log_addr   (i_log_addr),
        .i_new_alive  (i_new_alive),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_slot       (o_slot)
    );

    // Clock generation.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Applies one command to the table model and returns the result it gives.
    function automatic t_slot_result apply_table_command(
        input logic              cmd,
        input logic [ID_W-1:0]   id,
        input logic              hw,
        input logic [ADDR_W-1:0] saddr,
        input logic [ADDR_W-1:0] laddr,
        input logic              alive
    );
        t_slot_result res;
        int           found;
        found = -1;
        if (cmd == CMD_REGISTER) begin
            // Lowest slot without an alive mark takes every field.
            for (int k = 0; k < N_SLOTS && found < 0; k++) begin
                if (!tbl_alive[k]) begin
                    tbl_id[k]    = id;
                    tbl_hw[k]    = hw;
                    tbl_saddr[k] = saddr;
                    tbl_laddr[k] = laddr;
                    tbl_alive[k] = alive;
                    found        = k;
                end
            end
            res.status = (found >= 0) ? ST_OK : ST_FULL;
        end else begin
            // Lowest slot holding the id, alive or not, loses its alive mark.
            for (int k = 0; k < N_SLOTS && found < 0; k++) begin
                if (tbl_id[k] == id) begin
                    tbl_alive[k] = 1'b0;
                    found        = k;
                end
            end
            res.status = (found >= 0) ? ST_OK : ST_NOT_FOUND;
        end
        res.slot = (found >= 0) ? SLOT_OUT_W'(found) : '0;
        return res;
    endfunction

    // Drives one command, waits for its transfer and records the expected result.
    task automatic send_command(
        input logic              cmd,
        input logic [ID_W-1:0]   id,
        input logic              hw,
        input logic [ADDR_W-1:0] saddr,
        input logic [ADDR_W-1:0] laddr,
        input logic              alive
    );
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 40);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_app_id      <= id;
        i_on_hardware <= hw;
        i_state_addr  <= saddr;
        i_log_addr    <= laddr;
        i_new_alive   <= alive;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(apply_table_command(cmd, id, hw, saddr, laddr, alive));
    endtask

    // Receiver side: ready is dropped at random according to the current phase.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Every result transfer is compared with the oldest expected result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d slot %0d",
                         $time, o_status, o_slot);
                n_errors++;
            end else begin
                if (o_status !== pending_results[0].status) begin
                    $display("%0t: result %0d status expected %0d actual %0d",
                             $time, n_checked, pending_results[0].status, o_status);
                    n_errors++;
                end
                if (o_slot !== pending_results[0].slot) begin
                    $display("%0t: result %0d slot expected %0d actual %0d",
                             $time, n_checked, pending_results[0].slot, o_slot);
                    n_errors++;
                end
                void'(pending_results.pop_front());
                n_checked++;
            end
        end
    end

    // Watchdog on the length of the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL app_slot_table");
            $finish;
        end
    end

    // Cleared slots hold id zero, so a remove of zero finds slot 0; a wide id misses.
    task automatic test_reset_removes();
        send_command(CMD_REMOVE, '0, 1'b0, '0, '0, 1'b0);
        send_command(CMD_REMOVE, '1, 1'b1, '1, '1, 1'b1);
    endtask

    // An entry written without its alive mark is overwritten by the next
    // registration, and removing an entry that is already dead still succeeds.
    task automatic test_dead_entries();
        send_command(CMD_REGISTER, ID_W'(5), 1'b1, 32'h1234_5678, 32'h9abc_def0, 1'b0);
        send_command(CMD_REGISTER, ID_W'(6), 1'b0, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 1'b1);
        send_command(CMD_REMOVE, ID_W'(6), 1'b0, '0, '0, 1'b0);
        send_command(CMD_REMOVE, ID_W'(6), 1'b1, '1, '1, 1'b1);
    endtask

    // Fill every slot with extreme field values, register once more into a
    // full table, then free the first slot again.
    task automatic test_full_table();
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] saddr;
        for (int k = 0; k < N_SLOTS; k++) begin
            id    = (k == 0) ? '1 : (k == 1) ? '0 : id_pool[k % ID_POOL];
            saddr = k[0] ? '1 : '0;
            send_command(CMD_REGISTER, id, k[0], saddr, ~saddr, 1'b1);
        end
        send_command(CMD_REGISTER, ID_W'(77), 1'b1, '1, '1, 1'b1);
        send_command(CMD_REMOVE, '1, 1'b0, '0, '0, 1'b0);
    endtask

    // Random registrations and removals; the mix drifts so that the table both
    // fills up and drains, and removes often aim at ids held in the table.
    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int                reg_pct;
        int                pick;
        logic              cmd;
        logic [ID_W-1:0]   id;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        reg_pct     = 50;
        for (int n = 0; n < n_items; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(2))
                    0: begin
                        reg_pct = 20;
                    end
                    1: begin
                        reg_pct = 50;
                    end
                    default: begin
                        reg_pct = 85;
                    end
                endcase
            end
            cmd  = ($urandom_range(99) < reg_pct) ? CMD_REGISTER : CMD_REMOVE;
            pick = $urandom_range(99);
            if (pick < 45) begin
                id = id_pool[$urandom_range(ID_POOL - 1)];
            end else if (cmd == CMD_REMOVE && pick < 85) begin
                id = tbl_id[$urandom_range(N_SLOTS - 1)];
            end else begin
                id = ID_W'($urandom);
            end
            send_command(cmd, id, 1'($urandom), $urandom, $urandom,
                         $urandom_range(99) < 85);
        end
    endtask

    initial begin
        for (int k = 0; k < N_SLOTS; k++) begin
            tbl_id[k]    = '0;
            tbl_hw[k]    = 1'b0;
            tbl_saddr[k] = '0;
            tbl_laddr[k] = '0;
            tbl_alive[k] = 1'b0;
        end
        for (int k = 0; k < ID_POOL; k++) begin
            id_pool[k] = (k < 6) ? ID_W'(k) : ID_W'($urandom);
        end
        id_pool[ID_POOL - 1] = '1;

        // Reset is held at the start, then released.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_removes();
        test_dead_entries();
        test_full_table();
        test_random_traffic(430, 35, 50);
        test_random_traffic(430, 50, 35);
        test_random_traffic(430, 0, 0);

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (N_SLOTS + 8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS app_slot_table");
        end else begin
            $display("FAIL app_slot_table");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/ast_pkg.sv
hw/rtl/ast_cell.sv
hw/rtl/app_slot_table.sv
tb/tb_app_slot_table.sv
